// ----- design/hhls_pkg.sv -----
// Shared types, constants and helpers of the HTTP header length scanner.
`timescale 1ns / 1ps

package hhls_pkg;

    // Longest header scanned before the message is given up as having no header end.
    localparam int MAX_HEADER_BYTES = 65535;
    localparam int BYTE_COUNT_W     = $clog2(MAX_HEADER_BYTES + 1);

    localparam int DATA_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int HDR_LEN_W = 16;
    localparam int CLEN_W    = 31;
    localparam int FOUND_W   = 32;
    localparam int RESULT_W  = STATUS_W + HDR_LEN_W + CLEN_W;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [CLEN_W-1:0] VALUE_MAX = '1;

    // Header end sequence CR LF CR LF.
    localparam int END_SEQ_LEN = 4;
    localparam int END_POS_W   = $clog2(END_SEQ_LEN + 1);

    localparam logic [DATA_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [DATA_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [DATA_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CHAR_VT    = 8'h0B;
    localparam logic [DATA_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [DATA_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [DATA_W-1:0] CHAR_0     = 8'h30;
    localparam logic [DATA_W-1:0] CHAR_9     = 8'h39;
    localparam logic [DATA_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [DATA_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [DATA_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [DATA_W-1:0] CHAR_LC_C  = 8'h63;
    localparam logic [DATA_W-1:0] CASE_OFFSET = 8'h20;

    // Header name looked for, in lower case.
    localparam int NAME_LEN   = 14;
    localparam int NAME_POS_W = $clog2(NAME_LEN + 1);
    localparam logic [DATA_W-1:0] CL_NAME [NAME_LEN] = '{
        8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
        8'h2D, 8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
    };

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_num_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_END  = 2'd1,
        ST_NEG_LEN = 2'd2
    } t_status;

    // Per-byte control from the message tracker to the line parser.
    typedef struct packed {
        logic fire;   // a word is processed this cycle
        logic first;  // state is cleared before the word
        logic step;   // the word is part of the header scan
    } t_step_ctrl;

    // What the line parser reports about the line the current word ends.
    typedef struct packed {
        logic               cand;   // line ends here with the name and a colon
        logic [FOUND_W-1:0] value;  // two's complement value of that line
    } t_line_info;

    typedef struct packed {
        logic                 valid;
        t_status              status;
        logic [HDR_LEN_W-1:0] header_length;
        logic [CLEN_W-1:0]    content_length;
    } t_result;

    function automatic logic [DATA_W-1:0] to_lower(input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] r;
        r = c;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [DATA_W-1:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

endpackage

// ----- design/hhls_line_parser.sv -----
// Per-line matcher for the Content-Length name, the colon and the decimal value.
`timescale 1ns / 1ps

module hhls_line_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [hhls_pkg::DATA_W-1:0] i_byte,
    input  hhls_pkg::t_step_ctrl       i_ctrl,
    output hhls_pkg::t_line_info       o_line
);
    import hhls_pkg::*;

    logic [NAME_POS_W-1:0] r_name_pos, n_name_pos, eff_name_pos;
    logic                  r_has_name, n_has_name, eff_has_name;
    logic                  r_colon,    n_colon,    eff_colon;
    t_num_phase            r_phase,    n_phase,    eff_phase;
    logic                  r_neg,      n_neg,      eff_neg;
    logic [CLEN_W-1:0]     r_value,    n_value,    eff_value;

    logic              is_eol;
    logic [DATA_W-1:0] lc;
    logic [CLEN_W+3:0] times_ten;

    function automatic logic [CLEN_W:0] r_value_ext(input logic [CLEN_W-1:0] v);
        return {1'b0, v};
    endfunction

    assign is_eol = (i_byte == CHAR_CR) || (i_byte == CHAR_LF);
    assign lc     = to_lower(i_byte);

    // Value * 10 + digit, wide enough that it cannot wrap before saturation.
    assign times_ten = {r_value_ext(eff_value), 3'b000} + {2'b00, r_value_ext(eff_value), 1'b0}
                     + (CLEN_W+4)'(i_byte - CHAR_0);

    // A new message starts from a clean line.
    always_comb begin
        if (i_ctrl.first) begin
            eff_name_pos = '0;
            eff_has_name = 1'b0;
            eff_colon    = 1'b0;
            eff_phase    = PH_SKIP;
            eff_neg      = 1'b0;
            eff_value    = '0;
        end else begin
            eff_name_pos = r_name_pos;
            eff_has_name = r_has_name;
            eff_colon    = r_colon;
            eff_phase    = r_phase;
            eff_neg      = r_neg;
            eff_value    = r_value;
        end
    end

    always_comb begin
        logic       name_hit;
        logic       skip;
        t_num_phase ph;
        n_name_pos = r_name_pos;
        n_has_name = r_has_name;
        n_colon    = r_colon;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_value    = r_value;
        name_hit   = 1'b0;
        skip       = 1'b0;
        ph         = eff_phase;
        if (i_ctrl.fire) begin
            n_name_pos = eff_name_pos;
            n_has_name = eff_has_name;
            n_colon    = eff_colon;
            n_phase    = eff_phase;
            n_neg      = eff_neg;
            n_value    = eff_value;
            if (i_ctrl.step) begin
                if (is_eol) begin
                    n_name_pos = '0;
                    n_has_name = 1'b0;
                    n_colon    = 1'b0;
                    n_phase    = PH_SKIP;
                    n_neg      = 1'b0;
                    n_value    = '0;
                end else begin
                    if (!eff_has_name) begin
                        name_hit = (eff_name_pos < NAME_POS_W'(NAME_LEN))
                                && (lc == CL_NAME[eff_name_pos]);
                        if (name_hit) begin
                            n_name_pos = eff_name_pos + 1'b1;
                        end else begin
                            n_name_pos = (lc == CHAR_LC_C) ? NAME_POS_W'(1) : '0;
                        end
                        n_has_name = (n_name_pos >= NAME_POS_W'(NAME_LEN));
                    end
                    if (!eff_colon) begin
                        n_colon = (i_byte == CHAR_COLON);
                    end else begin
                        if (ph == PH_SKIP) begin
                            priority if (is_blank(i_byte)) begin
                                skip = 1'b1;
                            end else if (i_byte == CHAR_PLUS) begin
                                skip    = 1'b1;
                                n_phase = PH_DIGITS;
                            end else if (i_byte == CHAR_MINUS) begin
                                skip    = 1'b1;
                                n_phase = PH_DIGITS;
                                n_neg   = 1'b1;
                            end else begin
                                ph      = PH_DIGITS;
                                n_phase = PH_DIGITS;
                            end
                        end
                        if (!skip && ph == PH_DIGITS) begin
                            if (i_byte >= CHAR_0 && i_byte <= CHAR_9) begin
                                n_value = (times_ten > (CLEN_W+4)'(VALUE_MAX))
                                        ? VALUE_MAX : times_ten[CLEN_W-1:0];
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_pos <= '0;
            r_has_name <= 1'b0;
            r_colon    <= 1'b0;
            r_phase    <= PH_SKIP;
            r_neg      <= 1'b0;
            r_value    <= '0;
        end else begin
            r_name_pos <= n_name_pos;
            r_has_name <= n_has_name;
            r_colon    <= n_colon;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_value    <= n_value;
        end
    end

    // The line state before this word decides whether the ending line wins.
    always_comb begin
        o_line.cand  = is_eol && eff_has_name && eff_colon;
        o_line.value = eff_neg ? (FOUND_W'(0) - FOUND_W'(eff_value)) : FOUND_W'(eff_value);
    end

endmodule

// ----- design/hhls_msg_tracker.sv -----
// Message-level state: header end match, byte count, stored length and the result.
`timescale 1ns / 1ps

module hhls_msg_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [hhls_pkg::DATA_W-1:0] i_byte,
    input  logic                        i_first,
    input  logic                        i_last,
    input  hhls_pkg::t_line_info        i_line,
    output hhls_pkg::t_step_ctrl        o_ctrl,
    output hhls_pkg::t_result           o_result
);
    import hhls_pkg::*;

    logic [END_POS_W-1:0]    r_end_pos, n_end_pos, eff_end_pos;
    logic                    r_found,   n_found,   eff_found;
    logic [FOUND_W-1:0]      r_flen,    n_flen,    eff_flen;
    logic [BYTE_COUNT_W-1:0] r_count,   n_count,   eff_count;
    logic                    r_done,    n_done,    eff_done;

    logic              step;
    logic [DATA_W-1:0] end_char;

    always_comb begin
        eff_end_pos = i_first ? '0   : r_end_pos;
        eff_found   = i_first ? 1'b0 : r_found;
        eff_flen    = i_first ? '0   : r_flen;
        eff_count   = i_first ? '0   : r_count;
        eff_done    = i_first ? 1'b0 : r_done;
    end

    assign step     = i_fire && !eff_done && (i_byte != CHAR_NUL);
    assign end_char = eff_end_pos[0] ? CHAR_LF : CHAR_CR;

    always_comb begin
        o_ctrl.fire  = i_fire;
        o_ctrl.first = i_first;
        o_ctrl.step  = step;
    end

    always_comb begin
        n_end_pos = r_end_pos;
        n_found   = r_found;
        n_flen    = r_flen;
        n_count   = r_count;
        n_done    = r_done;
        o_result  = '{valid: 1'b0, status: ST_OK, header_length: '0, content_length: '0};
        if (i_fire) begin
            n_end_pos = eff_end_pos;
            n_found   = eff_found;
            n_flen    = eff_flen;
            n_count   = eff_count;
            n_done    = eff_done;
            if (!eff_done) begin
                if (i_byte == CHAR_NUL) begin
                    n_done          = 1'b1;
                    o_result.valid  = 1'b1;
                    o_result.status = ST_NO_END;
                end else begin
                    n_count = eff_count + 1'b1;
                    if (eff_end_pos < END_POS_W'(END_SEQ_LEN) && i_byte == end_char) begin
                        n_end_pos = eff_end_pos + 1'b1;
                    end else begin
                        n_end_pos = (i_byte == CHAR_CR) ? END_POS_W'(1) : '0;
                    end
                    if (i_line.cand && !eff_found) begin
                        n_found = 1'b1;
                        n_flen  = i_line.value;
                    end
                    priority if (n_end_pos >= END_POS_W'(END_SEQ_LEN)) begin
                        n_done         = 1'b1;
                        o_result.valid = 1'b1;
                        if (n_found && n_flen[FOUND_W-1]) begin
                            o_result.status = ST_NEG_LEN;
                        end else begin
                            o_result.status        = ST_OK;
                            o_result.header_length = HDR_LEN_W'(32'(n_count));
                            o_result.content_length =
                                n_found ? n_flen[CLEN_W-1:0] : '0;
                        end
                    end else if (i_last
                            || n_count >= BYTE_COUNT_W'(MAX_HEADER_BYTES)) begin
                        n_done          = 1'b1;
                        o_result.valid  = 1'b1;
                        o_result.status = ST_NO_END;
                    end else begin
                        n_done = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_pos <= '0;
            r_found   <= 1'b0;
            r_flen    <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_end_pos <= n_end_pos;
            r_found   <= n_found;
            r_flen    <= n_flen;
            r_count   <= n_count;
            r_done    <= n_done;
        end
    end

endmodule

// ----- design/http_header_length_scanner.sv -----
// Top level of the HTTP header length scanner: input register, scan logic, result register.
`timescale 1ns / 1ps
//
// The block takes a message one byte per word on the slave stream and reports, once per
// message, the length of the HTTP header (up to and including CR LF CR LF) and the value
// of the first Content-Length line. tuser bit 0 marks the first byte of a message and
// clears all scan state; tlast marks the last byte of the available buffer.
// A result word leaves on the master stream when the header end is seen, when a NUL byte,
// the buffer end or the header size limit comes first (status 1), or when the length is
// negative (status 2). Bytes after a result are dropped until the next first byte.
// Each accepted word is held in an input register and scanned once the result register
// can take what the scan gives; a result word is then held in the result register. A new
// word can be taken on every cycle as long as the result register is not blocked: the scan
// of one byte is a single pass through the name, header end and decimal matchers, and the
// only loop is the per-byte state update. When the receiver stalls the result register
// holds its word, the input register holds the next byte, and tready falls only once both are full.
// Reset (i_rst_n low at a clock edge) empties both registers and clears all scan state,
// as if a first byte had been seen.

module http_header_length_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [hhls_pkg::DATA_W-1:0]         i_s_axis_tdata,  // [7:0] data_byte
    input  logic                                i_s_axis_tuser,  // [0] first_byte
    input  logic                                i_s_axis_tlast,  // last_byte
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [1:0] status, [17:2] header_length, [48:18] content_length, [55:49] zero
    output logic [hhls_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import hhls_pkg::*;

    // Input register.
    logic              r_in_valid, n_in_valid;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_in_first;
    logic              r_in_last;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic [RESULT_W-1:0] r_out_data;

    logic       proceed;
    logic       s_fire;
    t_step_ctrl ctrl;
    t_line_info line_info;
    t_result    result;

    // The held byte is scanned whenever the result register can take what it may give.
    assign proceed         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proceed;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    hhls_line_parser u_line_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_ctrl  (ctrl),
        .o_line  (line_info)
    );

    hhls_msg_tracker u_msg_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proceed),
        .i_byte   (r_in_byte),
        .i_first  (r_in_first),
        .i_last   (r_in_last),
        .i_line   (line_info),
        .o_ctrl   (ctrl),
        .o_result (result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_fire) begin
            n_in_valid = 1'b1;
        end else if (proceed) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (proceed && result.valid) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_first <= i_s_axis_tuser;
            r_in_last  <= i_s_axis_tlast;
        end
        if (proceed && result.valid) begin
            r_out_data <= {result.content_length, result.header_length, result.status};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_data);

`ifndef SYNTHESIS
    // A byte waiting in the input register is never lost or overwritten.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proceed |=> r_in_valid && $stable(r_in_byte)
            && $stable(r_in_first) && $stable(r_in_last))
        else $error("input register lost a waiting byte");

    // Every result produced by the scan reaches the result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proceed && result.valid |=> o_m_axis_tvalid)
        else $error("scan result was not registered");

    // An error result carries no lengths.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (r_out_data[STATUS_W-1:0] != ST_OK)
            |-> (r_out_data[RESULT_W-1:STATUS_W] == '0))
        else $error("error result with nonzero length fields");

    // Nothing is scanned while the receiver holds off a full result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !proceed)
        else $error("scan advanced while the result register was blocked");
`endif

endmodule

// ----- tb/sv/http_header_length_scanner_tb.sv -----
// Self-checking testbench of the HTTP header length scanner, with its own scan predictor.
`timescale 1ns / 1ps
//
// Bytes of HTTP messages are fed to the block as words on the slave stream, one byte per
// word. Every accepted word is passed to a predictor that keeps its own copy of the scan
// state: the header end matcher, the per-line name matcher, the colon and number phases,
// the stored length and the byte count. It works out whether the byte ends the message
// and, if so, which result word must follow. Result words are taken off the master stream
// and compared field by field with the oldest expectation.
//
// The run starts with a directed set of short messages that visit each corner of the
// scan: the bare header end, letter case and blanks before the value, plus and minus
// signs, negative zero, saturation, the first matching line winning, lone CR and lone LF
// line ends, NUL bytes, the buffer end, a fresh first byte in the middle of a message,
// and bytes that follow a result. Then come randomised messages in four phases of
// back-pressure and sender gaps. Most are well formed headers with random lines and
// random Content-Length lines; the rest are truncated, poisoned with NUL, cut short by a
// restart, or plain noise.

module http_header_length_scanner_tb;

    import hhls_pkg::*;

    typedef logic [DATA_W-1:0] t_byte_q[$];

    typedef struct {
        t_status              status;
        logic [HDR_LEN_W-1:0] header_length;
        logic [CLEN_W-1:0]    content_length;
    } t_scan_result;

    // Predicts the scan of every accepted byte and holds the results still owed by the block.
    class header_scan_scoreboard;
        t_scan_result       expected_results[$];
        int unsigned        mismatches;
        int unsigned        bytes_scanned;
        int unsigned        results_predicted;

        logic [2:0]         end_pos;
        logic [3:0]         name_pos;
        bit                 line_named;
        bit                 colon_hit;
        t_num_phase         num_phase;
        bit                 neg;
        logic [CLEN_W-1:0]  mag;
        bit                 len_taken;
        logic [FOUND_W-1:0] taken_len;
        logic [31:0]        count;
        bit                 msg_done;

        function new();
            clear_message();
        endfunction

        function void clear_line();
            name_pos   = '0;
            line_named = 1'b0;
            colon_hit  = 1'b0;
            num_phase  = PH_SKIP;
            neg        = 1'b0;
            mag        = '0;
        endfunction

        function void clear_message();
            clear_line();
            end_pos   = '0;
            len_taken = 1'b0;
            taken_len = '0;
            count     = '0;
            msg_done  = 1'b0;
        endfunction

        function void give(t_status st, logic [HDR_LEN_W-1:0] hl, logic [CLEN_W-1:0] cl);
            t_scan_result r;
            r.status         = st;
            r.header_length  = hl;
            r.content_length = cl;
            expected_results.push_back(r);
            results_predicted++;
            msg_done = 1'b1;
        endfunction

        function void take_byte(logic [DATA_W-1:0] c, logic first, logic last);
            logic [DATA_W-1:0]  lc;
            logic [34:0]        prod;
            logic [FOUND_W-1:0] mag_ext;
            if (first) begin
                clear_message();
            end
            if (msg_done) begin
                return;
            end
            bytes_scanned++;
            if (c == CHAR_NUL) begin
                give(ST_NO_END, '0, '0);
                return;
            end
            count++;

            if (end_pos < END_SEQ_LEN && c == (end_pos[0] ? CHAR_LF : CHAR_CR)) begin
                end_pos++;
            end else begin
                end_pos = (c == CHAR_CR) ? 3'd1 : 3'd0;
            end

            if (c == CHAR_CR || c == CHAR_LF) begin
                // Line end: the first line with both the name and a colon fixes the length.
                if (!len_taken && line_named && colon_hit) begin
                    mag_ext   = {1'b0, mag};
                    len_taken = 1'b1;
                    taken_len = neg ? (32'd0 - mag_ext) : mag_ext;
                end
                clear_line();
            end else begin
                lc = (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + CASE_OFFSET : c;
                if (!line_named) begin
                    if (name_pos < NAME_LEN && lc == CL_NAME[name_pos]) begin
                        name_pos++;
                    end else begin
                        name_pos = (lc == CHAR_LC_C) ? 4'd1 : 4'd0;
                    end
                    line_named = (name_pos == NAME_LEN);
                end
                if (!colon_hit) begin
                    colon_hit = (c == CHAR_COLON);
                end else if (!(num_phase == PH_SKIP && (c == CHAR_SPACE || c == CHAR_TAB ||
                                                        c == CHAR_VT || c == CHAR_FF))) begin
                    if (num_phase == PH_SKIP && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                        num_phase = PH_DIGITS;
                        neg       = (c == CHAR_MINUS);
                    end else if (num_phase != PH_DONE) begin
                        num_phase = PH_DIGITS;
                        if (c >= CHAR_0 && c <= CHAR_9) begin
                            prod = 35'(mag) * 35'd10 + 35'(c - CHAR_0);
                            mag  = (prod > 35'(VALUE_MAX)) ? VALUE_MAX : prod[CLEN_W-1:0];
                        end else begin
                            num_phase = PH_DONE;
                        end
                    end
                end
            end

            if (end_pos == END_SEQ_LEN) begin
                if (len_taken && taken_len[FOUND_W-1]) begin
                    give(ST_NEG_LEN, '0, '0);
                end else begin
                    give(ST_OK, count[HDR_LEN_W-1:0], len_taken ? taken_len[CLEN_W-1:0] : '0);
                end
            end else if (last || count >= MAX_HEADER_BYTES) begin
                give(ST_NO_END, '0, '0);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            t_scan_result         want;
            logic [STATUS_W-1:0]  got_status;
            logic [HDR_LEN_W-1:0] got_hlen;
            logic [CLEN_W-1:0]    got_clen;
            got_status = word[STATUS_W-1:0];
            got_hlen   = word[STATUS_W +: HDR_LEN_W];
            got_clen   = word[STATUS_W + HDR_LEN_W +: CLEN_W];
            if (expected_results.size() == 0) begin
                $error("result word %h arrived with no result expected", word);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                mismatches++;
            end
            if (got_hlen !== want.header_length) begin
                $error("header_length: expected %0d, got %0d", want.header_length, got_hlen);
                mismatches++;
            end
            if (got_clen !== want.content_length) begin
                $error("content_length: expected %0d, got %0d", want.content_length, got_clen);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [DATA_W-1:0]      i_s_axis_tdata = '0;     // [7:0] data_byte
    logic                   i_s_axis_tuser = 1'b0;   // [0] first_byte
    logic                   i_s_axis_tlast = 1'b0;   // last_byte
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [1:0] status, [17:2] header_length, [48:18] content_length, [55:49] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    header_scan_scoreboard sb = new();

    http_header_length_scanner DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // The receiver decides afresh on every cycle whether it will take a result word.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Both streams are watched at the rising edge, where every input the testbench drives
    // still holds the value from before the edge, so the handshakes are seen as the block
    // sees them. Accepted bytes feed the predictor; accepted result words are checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.take_byte(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_result(o_m_axis_tdata);
            end
        end
    end

    // Offers one byte, after any random gap, and returns at the edge that accepts it.
    task automatic send_word(input logic [DATA_W-1:0] data, input logic first,
                             input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= first;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Sends a message with the first-byte flag on its opening byte and, where asked, on one
    // byte in the middle as well; the buffer end flag goes on the final byte when asked.
    task automatic send_message(input t_byte_q m, input bit mark_last, input int restart_at);
        foreach (m[i]) begin
            send_word(m[i], i == 0 || i == restart_at, mark_last && i == m.size() - 1);
        end
    endtask

    // Holds the sender back until every result owed so far has been taken off the block.
    // The first edge lets the byte accepted on the calling edge reach the predictor.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic void add_text(ref t_byte_q m, input string s);
        for (int k = 0; k < s.len(); k++) begin
            m.push_back(s[k]);
        end
    endfunction

    function automatic void add_crlf(ref t_byte_q m);
        m.push_back(CHAR_CR);
        m.push_back(CHAR_LF);
    endfunction

    // Appends one header line and its line end. A length line carries the name in random
    // letter case, now and then spoiled or with a stray byte in front, then blanks, a sign
    // and up to fourteen digits, sometimes followed by junk. Other lines are free text.
    // Most lines end in CR LF; a few end in a lone LF or a lone CR.
    function automatic void add_header_line(ref t_byte_q m, input bit with_name);
        logic [DATA_W-1:0] blanks [4];
        logic [DATA_W-1:0] c;
        int                spoil;
        int                ndig;
        int                ntext;
        int                r;
        blanks = '{CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF};
        ntext  = $urandom_range(0, 10);
        if (with_name) begin
            if ($urandom_range(0, 5) == 0) begin
                m.push_back($urandom_range(0, 1) ? CHAR_LC_C : CHAR_MINUS);
            end
            spoil = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NAME_LEN - 1) : -1;
            for (int k = 0; k < NAME_LEN; k++) begin
                c = CL_NAME[k];
                if (k == spoil) begin
                    c = c ^ 8'h01;
                end
                if (c inside {[8'h61:8'h7A]} && $urandom_range(0, 1) == 1) begin
                    c = c - CASE_OFFSET;
                end
                m.push_back(c);
            end
            repeat ($urandom_range(0, 1)) m.push_back(CHAR_SPACE);
            if ($urandom_range(0, 9) != 0) begin
                m.push_back(CHAR_COLON);
            end
            repeat ($urandom_range(0, 3)) m.push_back(blanks[$urandom_range(0, 3)]);
            r = $urandom_range(0, 99);
            if (r < 15) begin
                m.push_back(CHAR_PLUS);
            end else if (r < 35) begin
                m.push_back(CHAR_MINUS);
            end
            r    = $urandom_range(0, 99);
            ndig = (r < 8)  ? 0 :
                   (r < 75) ? $urandom_range(1, 5) :
                   (r < 90) ? $urandom_range(6, 10) : $urandom_range(11, 14);
            repeat (ndig) m.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
            ntext = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        end
        repeat (ntext) begin
            c = $urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7E))
                                     : 8'($urandom_range(1, 255));
            if (c == CHAR_CR || c == CHAR_LF) begin
                c = CHAR_COLON;
            end
            m.push_back(c);
        end
        r = $urandom_range(0, 99);
        if (r < 85) begin
            add_crlf(m);
        end else begin
            m.push_back((r < 93) ? CHAR_LF : CHAR_CR);
        end
    endfunction

    initial begin
        t_byte_q     m;
        int unsigned bytes_mark;
        int unsigned results_mark;
        int          kind;
        int          cut;
        int          restart_at;
        bit          mark_last;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed messages, with no gaps and no stalls.
        // The bare header end: length 4, no Content-Length.
        m = {}; add_crlf(m); add_crlf(m); send_message(m, 1'b0, -1);
        m = {}; add_text(m, "content-length:5"); add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, -1);
        // Negative zero is a valid length of zero.
        m = {}; add_text(m, "Content-Length: -0"); add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, -1);
        // Tab, vertical tab, form feed and space before a plus sign; junk after the digits.
        m = {}; add_text(m, "CONTENT-LENGTH:\011\013\014 +42x"); add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, -1);
        // A negative length gives the negative length status.
        m = {}; add_text(m, "content-length:  -7"); add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, -1);
        // Large values saturate at the largest positive value.
        m = {}; add_text(m, "Content-length: 98765432109876"); add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, -1);
        m = {}; add_text(m, "content-length:2147483647"); add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, -1);
        // The most negative value saturates in magnitude and is still negative.
        m = {}; add_text(m, "content-length:-2147483648"); add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, -1);
        // The colon ahead of the name still counts; that line wins with a value of zero.
        m = {}; add_text(m, "x: content-length 12"); add_crlf(m);
        add_text(m, "content-length: 3"); add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, -1);
        // A lone LF ends a line without a colon; a doubled c and a lone CR come next.
        m = {}; add_text(m, "content-length 9"); m.push_back(CHAR_LF);
        add_text(m, "ccontent-LENGTH:2147483647"); m.push_back(CHAR_CR);
        add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, -1);
        // The first winning line holds; bytes after the result are ignored.
        m = {}; add_text(m, "content-length:8"); add_crlf(m);
        add_text(m, "Content-Length:4"); add_crlf(m); add_crlf(m);
        add_text(m, "body"); m.push_back(CHAR_NUL);
        send_message(m, 1'b0, -1);
        // A NUL byte gives up at once; the bytes after it are ignored.
        m = {}; add_text(m, "ab"); m.push_back(CHAR_NUL); add_text(m, "cd");
        send_message(m, 1'b0, -1);
        // The buffer end before the header end, with the highest and lowest non-NUL byte values.
        m = {}; add_text(m, "GET \377\001\200/"); send_message(m, 1'b1, -1);
        // The buffer end on the byte that completes the header end still reports success.
        m = {}; add_text(m, "Host:a"); add_crlf(m); add_crlf(m); send_message(m, 1'b1, -1);
        // A new first byte in the middle of a message starts the scan afresh.
        m = {}; add_text(m, "content-length:1"); add_crlf(m); add_crlf(m);
        send_message(m, 1'b0, 3);
        wait_drained();

        // Random messages in four phases: no idling, sender gaps, receiver stalls, both.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 53; recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 53;
                end
                default: begin
                    send_idle_pct = 30; recv_stall_pct = 30;
                end
            endcase
            bytes_mark   = sb.bytes_scanned;
            results_mark = sb.results_predicted;
            while (sb.bytes_scanned - bytes_mark < 250 ||
                   sb.results_predicted - results_mark < 6) begin
                kind = $urandom_range(0, 99);
                if (kind < 12) begin
                    // Noise: any byte, with the first and last flags set now and then.
                    repeat ($urandom_range(1, 24)) begin
                        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                                  $urandom_range(0, 7) == 0);
                    end
                end else begin
                    m = {};
                    add_header_line(m, 1'b0);
                    repeat ($urandom_range(0, 3)) begin
                        add_header_line(m, $urandom_range(0, 99) < 45);
                    end
                    add_crlf(m);
                    add_crlf(m);
                    mark_last  = 1'b0;
                    restart_at = -1;
                    if (kind < 22) begin
                        // Truncated buffer.
                        cut = $urandom_range(1, m.size());
                        while (m.size() > cut) begin
                            void'(m.pop_back());
                        end
                        mark_last = 1'b1;
                    end else if (kind < 30) begin
                        m[$urandom_range(0, m.size() - 1)] = CHAR_NUL;
                    end else if (kind < 37) begin
                        mark_last = 1'b1;
                    end else if (kind < 42) begin
                        restart_at = $urandom_range(1, m.size() - 1);
                    end else if (kind < 60) begin
                        // A body that the block has to drop.
                        repeat ($urandom_range(1, 6)) m.push_back(8'($urandom_range(0, 255)));
                    end
                    send_message(m, mark_last, restart_at);
                end
            end
            wait_drained();
        end

        // A few more cycles to catch any result word that should not be there.
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("http_header_length_scanner verification clean");
        end else begin
            $display("http_header_length_scanner verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("http_header_length_scanner verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/hhls_pkg.sv
design/hhls_line_parser.sv
design/hhls_msg_tracker.sv
design/http_header_length_scanner.sv
tb/sv/http_header_length_scanner_tb.sv
